// File: rtl/core/isotp_receive_reassembler_top_defines.svh
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_top_defines.svh
// Assertion macros shared by the ISO-TP receive reassembler RTL.
// ----------------------------------------------------------------------------
`ifndef ISOTP_RECEIVE_REASSEMBLER_TOP_DEFINES_SVH
`define ISOTP_RECEIVE_REASSEMBLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ISOTP_RR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isotp_rr: same-cycle check failed");
// next-cycle implication
`define ISOTP_RR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isotp_rr: next-cycle check failed");
`else
`define ISOTP_RR_ASSERT_IMP(label, clk, rst, ante, cons)
`define ISOTP_RR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/isotp_rr_pkg.sv
// ----------------------------------------------------------------------------
// isotp_rr_pkg
// Types and codes for the ISO-TP receive reassembler.
// ----------------------------------------------------------------------------
package isotp_rr_pkg;

   localparam int ID_W   = 29;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 12;
   localparam int EV_W   = 3;
   localparam int ERR_W  = 3;
   localparam int CSR_IDX_W = 2;

   // result events
   localparam logic [EV_W-1:0] EV_BYTE    = 3'd0;
   localparam logic [EV_W-1:0] EV_SEND_FC = 3'd1;
   localparam logic [EV_W-1:0] EV_TAKEN   = 3'd2;
   localparam logic [EV_W-1:0] EV_DONE    = 3'd3;
   localparam logic [EV_W-1:0] EV_PEER_FC = 3'd4;
   localparam logic [EV_W-1:0] EV_DROP    = 3'd5;
   localparam logic [EV_W-1:0] EV_FOREIGN = 3'd6;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_SINGLE_LEN = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NO_FIRST   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_SEQUENCE   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TYPE       = 3'd5;

   // frame types (upper nibble of byte zero)
   localparam logic [3:0] FT_SINGLE = 4'd0;
   localparam logic [3:0] FT_FIRST  = 4'd1;
   localparam logic [3:0] FT_CONSEC = 4'd2;
   localparam logic [3:0] FT_FLOW   = 4'd3;

   localparam logic [3:0] SF_MAX_LEN   = 4'd7;
   localparam logic [2:0] FF_MAX_BYTES = 3'd6;
   localparam logic [2:0] CF_MAX_BYTES = 3'd7;
   localparam logic [3:0] SEQ_START    = 4'd1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ID      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_ID        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATION_TIME = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   channel_id;
      logic [ID_W-1:0]   reply_id;
      logic [BYTE_W-1:0] block_size;
      logic [BYTE_W-1:0] separation_time;
   } cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]             frame_id;
      logic [7:0][BYTE_W-1:0]      data;     // data[0] is byte zero
   } frame_type;

   // everything the emitter needs to replay one frame's results
   typedef struct packed {
      logic [2:0]             nbytes;
      logic [6:0][BYTE_W-1:0] data;
      logic [LEN_W-1:0]       base;
      logic [LEN_W-1:0]       len;
      logic                   fc;
      logic [EV_W-1:0]        fin_ev;
      logic [BYTE_W-1:0]      fin_a;
      logic [BYTE_W-1:0]      fin_b;
      logic [ERR_W-1:0]       fin_err;
   } plan_type;

   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [BYTE_W-1:0] value_a;
      logic [BYTE_W-1:0] value_b;
      logic [LEN_W-1:0]  byte_offset;
      logic [LEN_W-1:0]  message_length;
      logic [ERR_W-1:0]  error_code;
      logic [ID_W-1:0]   target_id;
      logic              last;
   } result_type;

endpackage

// File: rtl/core/isotp_rr_req_if.sv
// ----------------------------------------------------------------------------
// isotp_rr_req_if
// CAN frame channel: valid/ready with identifier and eight data bytes.
// ----------------------------------------------------------------------------
interface isotp_rr_req_if;
   import isotp_rr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   frame_id;
   logic [BYTE_W-1:0] byte_zero;
   logic [BYTE_W-1:0] byte_one;
   logic [BYTE_W-1:0] byte_two;
   logic [BYTE_W-1:0] byte_three;
   logic [BYTE_W-1:0] byte_four;
   logic [BYTE_W-1:0] byte_five;
   logic [BYTE_W-1:0] byte_six;
   logic [BYTE_W-1:0] byte_seven;

   modport source (
      output valid, frame_id, byte_zero, byte_one, byte_two, byte_three,
             byte_four, byte_five, byte_six, byte_seven,
      input  ready
   );

   modport sink (
      input  valid, frame_id, byte_zero, byte_one, byte_two, byte_three,
             byte_four, byte_five, byte_six, byte_seven,
      output ready
   );
endinterface

// File: rtl/core/isotp_rr_rsp_if.sv
// ----------------------------------------------------------------------------
// isotp_rr_rsp_if
// Result channel: valid/ready with one reassembler result per transaction.
// ----------------------------------------------------------------------------
interface isotp_rr_rsp_if;
   import isotp_rr_pkg::*;

   logic              valid;
   logic              ready;
   logic [EV_W-1:0]   event_res;
   logic [BYTE_W-1:0] value_a;
   logic [BYTE_W-1:0] value_b;
   logic [LEN_W-1:0]  byte_offset;
   logic [LEN_W-1:0]  message_length;
   logic [ERR_W-1:0]  error_code;
   logic [ID_W-1:0]   target_id;
   logic              last;

   modport source (
      output valid, event_res, value_a, value_b, byte_offset, message_length,
             error_code, target_id, last,
      input  ready
   );

   modport sink (
      input  valid, event_res, value_a, value_b, byte_offset, message_length,
             error_code, target_id, last,
      output ready
   );
endinterface

// File: rtl/core/isotp_rr_decode.sv
// ----------------------------------------------------------------------------
// isotp_rr_decode
// Frame classifier and session state; builds the result plan of one frame.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_top_defines.svh"

module isotp_rr_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  isotp_rr_pkg::frame_type frame,
   input  isotp_rr_pkg::cfg_type  cfg,
   output isotp_rr_pkg::plan_type plan
);
   import isotp_rr_pkg::*;

   logic [LEN_W-1:0] el_ff, el_in;
   logic [LEN_W-1:0] rc_ff, rc_in;
   logic [3:0]       seq_ff, seq_in;
   logic [7:0]       fl_ff, fl_in;

   logic [3:0]       ftype, low;
   logic             own;
   logic [LEN_W-1:0] ff_len, remain, new_rc;
   logic [2:0]       ff_n, cf_n;

   assign ftype  = frame.data[0][7:4];
   assign low    = frame.data[0][3:0];
   assign own    = (frame.frame_id == cfg.channel_id);
   assign ff_len = {low, frame.data[1]};
   assign ff_n   = (ff_len < LEN_W'(FF_MAX_BYTES)) ? ff_len[2:0] : FF_MAX_BYTES;
   assign remain = (rc_ff < el_ff) ? (el_ff - rc_ff) : '0;
   assign cf_n   = (remain > LEN_W'(CF_MAX_BYTES)) ? CF_MAX_BYTES : remain[2:0];
   assign new_rc = rc_ff + LEN_W'(cf_n);

   always_comb begin
      plan         = '0;
      plan.len     = el_ff;
      plan.data    = frame.data[7:1];
      plan.fin_err = ERR_NONE;
      el_in        = el_ff;
      rc_in        = rc_ff;
      seq_in       = seq_ff;
      fl_in        = fl_ff;

      if (!own) begin
         plan.fin_ev = EV_FOREIGN;
      end else begin
         case (ftype)
            FT_SINGLE: begin
               el_in  = '0;
               rc_in  = '0;
               seq_in = '0;
               fl_in  = '0;
               if (low > SF_MAX_LEN) begin
                  plan.fin_ev  = EV_DROP;
                  plan.fin_err = ERR_SINGLE_LEN;
                  plan.len     = '0;
               end else begin
                  plan.nbytes = low[2:0];
                  plan.len    = LEN_W'(low);
                  plan.fin_ev = EV_DONE;
               end
            end
            FT_FIRST: begin
               plan.data   = {8'h00, frame.data[7:2]};
               plan.nbytes = ff_n;
               plan.len    = ff_len;
               plan.fc     = 1'b1;
               plan.fin_ev = EV_TAKEN;
               el_in       = ff_len;
               rc_in       = LEN_W'(ff_n);
               seq_in      = SEQ_START;
               fl_in       = cfg.block_size;
            end
            FT_CONSEC: begin
               if (el_ff == '0) begin
                  plan.fin_ev  = EV_DROP;
                  plan.fin_err = ERR_NO_FIRST;
                  plan.len     = '0;
               end else if (low != seq_ff) begin
                  plan.fin_ev  = EV_DROP;
                  plan.fin_err = ERR_SEQUENCE;
                  plan.len     = '0;
                  el_in        = '0;
                  rc_in        = '0;
               end else begin
                  plan.nbytes = cf_n;
                  plan.base   = rc_ff;
                  rc_in       = new_rc;
                  seq_in      = seq_ff + 4'd1;
                  if (new_rc >= el_ff) begin
                     plan.fin_ev = EV_DONE;
                     el_in       = '0;
                     rc_in       = '0;
                     seq_in      = '0;
                     fl_in       = '0;
                  end else begin
                     plan.fin_ev = EV_TAKEN;
                     if (fl_ff == 8'd1) begin
                        plan.fc = 1'b1;
                        fl_in   = cfg.block_size;
                     end else if (fl_ff != 8'd0) begin
                        fl_in = fl_ff - 8'd1;
                     end
                  end
               end
            end
            FT_FLOW: begin
               plan.fin_ev = EV_PEER_FC;
               plan.fin_a  = frame.data[1];
               plan.fin_b  = frame.data[2];
            end
            default: begin
               plan.fin_ev  = EV_DROP;
               plan.fin_err = ERR_TYPE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         el_ff  <= '0;
         rc_ff  <= '0;
         seq_ff <= '0;
         fl_ff  <= '0;
      end else if (accept) begin
         el_ff  <= el_in;
         rc_ff  <= rc_in;
         seq_ff <= seq_in;
         fl_ff  <= fl_in;
      end
   end

   // byte count never passes the announced length
   `ISOTP_RR_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, rc_ff <= el_ff)
   // a first frame on this channel always arms the sequence counter
   `ISOTP_RR_ASSERT_NXT(a_first_arms_seq, clock, reset, accept && own && (ftype == FT_FIRST), seq_ff == SEQ_START)

endmodule

// File: rtl/core/isotp_rr_emit.sv
// ----------------------------------------------------------------------------
// isotp_rr_emit
// Plan register and result sequencer: one result per cycle into an
// output register, unless the receiver stalls.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_top_defines.svh"

module isotp_rr_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  isotp_rr_pkg::cfg_type    cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  isotp_rr_pkg::plan_type   plan_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output isotp_rr_pkg::result_type out_res
);
   import isotp_rr_pkg::*;

   plan_type   plan_ff;
   logic       plan_valid_ff, plan_valid_in;
   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   result_type res_ff, res_in;

   logic is_byte, is_fc, is_final, gen, in_accept;

   assign is_byte   = idx_ff < {1'b0, plan_ff.nbytes};
   assign is_fc     = plan_ff.fc && (idx_ff == {1'b0, plan_ff.nbytes});
   assign is_final  = !is_byte && !is_fc;
   assign gen       = plan_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready  = !plan_valid_ff || (gen && is_final);
   assign in_accept = in_valid && in_ready;

   always_comb begin
      res_in                = '0;
      res_in.message_length = plan_ff.len;
      res_in.last           = is_final;
      if (is_byte) begin
         res_in.event_res   = EV_BYTE;
         res_in.value_a     = plan_ff.data[idx_ff[2:0]];
         res_in.byte_offset = plan_ff.base + LEN_W'(idx_ff);
      end else if (is_fc) begin
         res_in.event_res = EV_SEND_FC;
         res_in.value_a   = cfg.block_size;
         res_in.value_b   = cfg.separation_time;
         res_in.target_id = cfg.reply_id;
      end else begin
         res_in.event_res  = plan_ff.fin_ev;
         res_in.value_a    = plan_ff.fin_a;
         res_in.value_b    = plan_ff.fin_b;
         res_in.error_code = plan_ff.fin_err;
      end
   end

   always_comb begin
      plan_valid_in = plan_valid_ff;
      idx_in        = idx_ff;
      if (in_accept) begin
         plan_valid_in = 1'b1;
         idx_in        = '0;
      end else if (gen) begin
         if (is_final) begin
            plan_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
      out_valid_in = gen ? 1'b1 : (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         plan_ff <= plan_in;
      end
      if (gen) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res   = res_ff;

   // plan retires once its final result is loaded, unless refilled
   `ISOTP_RR_ASSERT_NXT(a_plan_retires, clock, reset, gen && is_final && !in_accept, !plan_valid_ff)
   // sequencer never walks past the last result of the plan
   `ISOTP_RR_ASSERT_IMP(a_idx_bound, clock, reset, plan_valid_ff, idx_ff <= ({1'b0, plan_ff.nbytes} + {3'b000, plan_ff.fc}))

endmodule

// File: rtl/core/isotp_receive_reassembler_top.sv
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_top
// ISO-TP (ISO 15765-2) receive reassembler for one CAN channel.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one classic CAN frame per transaction (identifier and
//    eight data bytes). rsp_chan carries one result per transaction; the
//    final result of each frame has last set.
//  - csr_we/csr_index/csr_wdata write channel_id, reply_id, block_size and
//    separation_time; write them only while no frame is in flight.
//  - A frame yields 1 to 9 results (single: up to 8, first: up to 8,
//    consecutive: up to 9, others: 1). Results leave one per cycle unless stalled.
//  - Path: the frame transaction loads the plan register, the sequencer
//    then loads the first result into the output register, and that
//    result can be taken from there by the receiver.
//  - Back-to-back: the result sequencer is busy until a frame's last result
//    is loaded; the next frame is taken in the cycle that last result enters
//    the output register, so back-to-back frames leave no gap.
//  - Receiver stall: the output register holds its result and the sequencer
//    waits; req_chan.ready drops once the plan register is occupied.
//  - Reset: session state (length, count, sequence, block counter) and the
//    configuration registers clear to zero; no results are pending.
// ----------------------------------------------------------------------------
module isotp_receive_reassembler_top (
   input  logic                                  clock,
   input  logic                                  reset,
   isotp_rr_req_if.sink                          req_chan,
   isotp_rr_rsp_if.source                        rsp_chan,
   input  logic                                  csr_we,
   input  logic [isotp_rr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [isotp_rr_pkg::ID_W-1:0]         csr_wdata
);
   import isotp_rr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   frame_type  frame;
   plan_type   plan;
   result_type res;
   logic       req_accept;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_ID:      cfg_in.channel_id      = csr_wdata;
            CSR_REPLY_ID:        cfg_in.reply_id        = csr_wdata;
            CSR_BLOCK_SIZE:      cfg_in.block_size      = csr_wdata[BYTE_W-1:0];
            CSR_SEPARATION_TIME: cfg_in.separation_time = csr_wdata[BYTE_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // incoming frame
   assign frame.frame_id = req_chan.frame_id;
   assign frame.data     = {req_chan.byte_seven, req_chan.byte_six, req_chan.byte_five,
                            req_chan.byte_four, req_chan.byte_three, req_chan.byte_two,
                            req_chan.byte_one, req_chan.byte_zero};
   assign req_accept     = req_chan.valid && req_chan.ready;

   // classify the frame and advance the session on the transaction
   isotp_rr_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .frame  (frame),
      .cfg    (cfg_ff),
      .plan   (plan)
   );

   // replay the plan, one result per cycle while rsp_chan is not stalled
   isotp_rr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .plan_in   (plan),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_res   (res)
   );

   assign rsp_chan.event_res      = res.event_res;
   assign rsp_chan.value_a        = res.value_a;
   assign rsp_chan.value_b        = res.value_b;
   assign rsp_chan.byte_offset    = res.byte_offset;
   assign rsp_chan.message_length = res.message_length;
   assign rsp_chan.error_code     = res.error_code;
   assign rsp_chan.target_id      = res.target_id;
   assign rsp_chan.last           = res.last;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ISO-TP receive reassembler. A clocked driver
// feeds CAN frames from a queue and a clocked monitor checks every result,
// field by field, against the reassembly events that a behavioral session
// tracker in this module works out. The run steps through several register
// settings, with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import isotp_rr_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;  // generous; the slowest legal run is far shorter
   localparam int SETTLE_CYCLES = 16;     // a frame never produces more than nine results
   localparam int PHASE_FRAMES  = 46;     // random frames per register setting; half in the first

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CHANNEL_ID;
   logic [ID_W-1:0]      csr_wdata = '0;

   isotp_rr_req_if req_if ();
   isotp_rr_rsp_if rsp_if ();

   isotp_receive_reassembler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow registers and session state of the receiver
   // ------------------------------------------------------------------------
   logic [ID_W-1:0]   cfg_channel = '0;
   logic [ID_W-1:0]   cfg_reply   = '0;
   logic [BYTE_W-1:0] cfg_block   = '0;
   logic [BYTE_W-1:0] cfg_sep     = '0;

   logic [LEN_W-1:0]  msg_len    = '0;  // 0 means no message in progress
   logic [LEN_W-1:0]  rx_count   = '0;
   logic [3:0]        seq_next   = '0;
   logic [BYTE_W-1:0] block_left = '0;

   frame_type  frame_queue[$];     // frames waiting for the driver
   result_type frame_events[$];    // events of the frame being reassembled
   result_type awaited_events[$];  // events the block still owes us

   frame_type in_flight;
   int  frames_posted   = 0;
   int  frames_accepted = 0;
   int  results_checked = 0;
   int  settings_count  = 0;
   int  fail_count      = 0;
   int  cycle_count     = 0;
   int  req_hold        = 0;
   int  rsp_hold        = 0;
   bit  req_idle_on     = 1'b0;
   bit  rsp_idle_on     = 1'b0;

   // ------------------------------------------------------------------------
   // Session tracker: the events one accepted frame must produce
   // ------------------------------------------------------------------------
   function automatic void emit(logic [EV_W-1:0] ev, logic [BYTE_W-1:0] a,
                                logic [BYTE_W-1:0] b, logic [LEN_W-1:0] off,
                                logic [LEN_W-1:0] len, logic [ERR_W-1:0] err,
                                logic [ID_W-1:0] tgt);
      result_type r;
      r.event_res      = ev;
      r.value_a        = a;
      r.value_b        = b;
      r.byte_offset    = off;
      r.message_length = len;
      r.error_code     = err;
      r.target_id      = tgt;
      r.last           = 1'b0;
      frame_events.push_back(r);
   endfunction

   function automatic void clear_session();
      msg_len    = '0;
      rx_count   = '0;
      seq_next   = '0;
      block_left = '0;
   endfunction

   function automatic void request_flow_control();
      emit(EV_SEND_FC, cfg_block, cfg_sep, '0, msg_len, ERR_NONE, cfg_reply);
   endfunction

   function automatic void reassemble_frame(frame_type f);
      logic [3:0]       ftype;
      logic [3:0]       low;
      logic [LEN_W-1:0] done_len;
      int               take;
      frame_events.delete();
      ftype = f.data[0][7:4];
      low   = f.data[0][3:0];
      if (f.frame_id != cfg_channel) begin
         emit(EV_FOREIGN, '0, '0, '0, msg_len, ERR_NONE, '0);
      end else begin
         case (ftype)
            FT_SINGLE: begin
               clear_session();
               if (low > SF_MAX_LEN) begin
                  emit(EV_DROP, '0, '0, '0, '0, ERR_SINGLE_LEN, '0);
               end else begin
                  for (int i = 0; i < low; i++)
                     emit(EV_BYTE, f.data[1+i], '0, LEN_W'(i), LEN_W'(low), ERR_NONE, '0);
                  emit(EV_DONE, '0, '0, '0, LEN_W'(low), ERR_NONE, '0);
               end
            end
            FT_FIRST: begin
               clear_session();
               msg_len = {low, f.data[1]};
               take = (msg_len < FF_MAX_BYTES) ? msg_len : FF_MAX_BYTES;
               for (int i = 0; i < take; i++)
                  emit(EV_BYTE, f.data[2+i], '0, LEN_W'(i), msg_len, ERR_NONE, '0);
               rx_count = LEN_W'(take);
               seq_next = SEQ_START;
               request_flow_control();
               block_left = cfg_block;
               emit(EV_TAKEN, '0, '0, '0, msg_len, ERR_NONE, '0);
            end
            FT_CONSEC: begin
               if (msg_len == 0) begin
                  emit(EV_DROP, '0, '0, '0, '0, ERR_NO_FIRST, '0);
               end else if (low != seq_next) begin
                  // message abandoned; sequence and block counter are left alone
                  msg_len  = '0;
                  rx_count = '0;
                  emit(EV_DROP, '0, '0, '0, '0, ERR_SEQUENCE, '0);
               end else begin
                  take = (rx_count < msg_len) ? msg_len - rx_count : 0;
                  if (take > CF_MAX_BYTES)
                     take = CF_MAX_BYTES;
                  for (int i = 0; i < take; i++)
                     emit(EV_BYTE, f.data[1+i], '0, LEN_W'(rx_count + i), msg_len,
                          ERR_NONE, '0);
                  rx_count = rx_count + LEN_W'(take);
                  seq_next = seq_next + 4'd1;
                  if (rx_count >= msg_len) begin
                     done_len = msg_len;
                     clear_session();
                     emit(EV_DONE, '0, '0, '0, done_len, ERR_NONE, '0);
                  end else begin
                     if (block_left > 0) begin
                        block_left = block_left - 8'd1;
                        if (block_left == 0) begin
                           request_flow_control();
                           block_left = cfg_block;
                        end
                     end
                     emit(EV_TAKEN, '0, '0, '0, msg_len, ERR_NONE, '0);
                  end
               end
            end
            FT_FLOW: emit(EV_PEER_FC, f.data[1], f.data[2], '0, msg_len, ERR_NONE, '0);
            default: emit(EV_DROP, '0, '0, '0, msg_len, ERR_TYPE, '0);
         endcase
      end
      frame_events[frame_events.size()-1].last = 1'b1;
      foreach (frame_events[i])
         awaited_events.push_back(frame_events[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------------
   // Idle cycles before the next transaction; about half are zero when idling is on.
   function automatic int draw_wait(bit on);
      if (on && $urandom_range(0, 1) == 1)
         return $urandom_range(0, 17);
      return 0;
   endfunction

   function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   function automatic logic [ID_W-1:0] foreign_id();
      if ($urandom_range(0, 1) == 1)
         return cfg_channel ^ (ID_W'(1) << $urandom_range(0, ID_W-1));
      return ID_W'($urandom);
   endfunction

   // frame with a given byte zero and random payload bytes
   function automatic frame_type mk_frame(logic [ID_W-1:0] id, logic [BYTE_W-1:0] b0);
      frame_type f;
      f.frame_id = id;
      f.data[0]  = b0;
      for (int i = 1; i < 8; i++)
         f.data[i] = BYTE_W'($urandom);
      return f;
   endfunction

   function automatic void post(frame_type f);
      frame_queue.push_back(f);
      frames_posted++;
   endfunction

   // A first frame and its consecutive frames. cf_limit cuts a long message
   // short; break_seq spoils the sequence number of the final consecutive frame.
   function automatic void send_message(logic [LEN_W-1:0] len, int cf_limit, bit break_seq);
      frame_type  f;
      int         n_cf;
      logic [3:0] seq;
      f = mk_frame(cfg_channel, {FT_FIRST, len[11:8]});
      f.data[1] = len[7:0];
      post(f);
      if (len == 0)
         n_cf = 0;
      else if (len <= FF_MAX_BYTES)
         n_cf = 1;  // short message still needs one consecutive frame to close
      else
         n_cf = (len - FF_MAX_BYTES + CF_MAX_BYTES - 1) / CF_MAX_BYTES;
      if (n_cf > cf_limit)
         n_cf = cf_limit;
      seq = SEQ_START;
      for (int i = 0; i < n_cf; i++) begin
         if (break_seq && i == n_cf - 1)
            post(mk_frame(cfg_channel, {FT_CONSEC, 4'(seq + $urandom_range(1, 15))}));
         else
            post(mk_frame(cfg_channel, {FT_CONSEC, seq}));
         // now and then a frame that must not disturb the open message
         case ($urandom_range(0, 23))
            0: post(mk_frame(foreign_id(), BYTE_W'($urandom)));
            1: post(mk_frame(cfg_channel, {FT_FLOW, 4'($urandom)}));
            2: post(mk_frame(cfg_channel, {4'($urandom_range(4, 15)), 4'($urandom)}));
            default: ;
         endcase
         seq = seq + 4'd1;
      end
   endfunction

   task automatic random_traffic(int n);
      int               goal;
      int               pick;
      int               sel;
      logic [LEN_W-1:0] len;
      goal = frames_posted + n;
      while (frames_posted < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // messages, mostly short and well formed; a few wrap the sequence
            // number, a few are cut off after a long length, some end out of sequence
            sel = $urandom_range(0, 19);
            if (sel < 15)
               len = LEN_W'($urandom_range(0, 40));
            else if (sel < 19)
               len = LEN_W'($urandom_range(41, 130));
            else
               len = LEN_W'($urandom);
            send_message(len, (sel == 19) ? $urandom_range(1, 4) : 1000,
                         $urandom_range(0, 9) == 0);
         end else if (pick < 75) begin
            post(mk_frame(cfg_channel, {FT_SINGLE, 4'($urandom)}));
         end else if (pick < 82) begin
            post(mk_frame(cfg_channel, {FT_CONSEC, 4'($urandom)}));
         end else if (pick < 88) begin
            post(mk_frame(cfg_channel, {FT_FLOW, 4'($urandom)}));
         end else if (pick < 94) begin
            post(mk_frame(cfg_channel, BYTE_W'($urandom)));
         end else begin
            post(mk_frame(foreign_id(), BYTE_W'($urandom)));
         end
      end
   endtask

   // One register write per call; the shadow copy follows at once since
   // writes only happen while the block is idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ID_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CHANNEL_ID: cfg_channel = value;
         CSR_REPLY_ID:   cfg_reply   = value;
         CSR_BLOCK_SIZE: cfg_block   = value[BYTE_W-1:0];
         default:        cfg_sep     = value[BYTE_W-1:0];
      endcase
   endtask

   // Upper bits of the 8-bit registers get junk to check that they are ignored.
   task automatic apply_setting(logic [ID_W-1:0] ch, logic [ID_W-1:0] rp,
                                logic [BYTE_W-1:0] bs, logic [BYTE_W-1:0] st,
                                bit rq_idle, bit rs_idle);
      write_reg(CSR_CHANNEL_ID, ch);
      write_reg(CSR_REPLY_ID, rp);
      write_reg(CSR_BLOCK_SIZE, {21'($urandom), bs});
      write_reg(CSR_SEPARATION_TIME, {21'($urandom), st});
      @(posedge clock);
      csr_we <= 1'b0;
      req_idle_on = rq_idle;
      rsp_idle_on = rs_idle;
      settings_count++;
   endtask

   // Block is idle once every posted frame is taken and every event has come.
   task automatic wait_idle();
      while (frames_accepted != frames_posted || awaited_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers queued frames; the tracker runs on each accepted transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            reassemble_frame(in_flight);
            frames_accepted++;
         end
         if (req_if.valid && !req_if.ready) begin
            // stalled: keep the frame on the bus
         end else if (req_hold > 0) begin
            req_hold--;
            req_if.valid <= 1'b0;
         end else if (frame_queue.size() > 0) begin
            in_flight = frame_queue.pop_front();
            req_if.frame_id   <= in_flight.frame_id;
            req_if.byte_zero  <= in_flight.data[0];
            req_if.byte_one   <= in_flight.data[1];
            req_if.byte_two   <= in_flight.data[2];
            req_if.byte_three <= in_flight.data[3];
            req_if.byte_four  <= in_flight.data[4];
            req_if.byte_five  <= in_flight.data[5];
            req_if.byte_six   <= in_flight.data[6];
            req_if.byte_seven <= in_flight.data[7];
            req_if.valid      <= 1'b1;
            req_hold = draw_wait(req_idle_on);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result transaction against the oldest awaited event
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      int         bad;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_events.size() == 0) begin
               $error("result with nothing awaited: event_res %0d", rsp_if.event_res);
               fail_count++;
            end else begin
               want = awaited_events.pop_front();
               bad = field_check("event_res", want.event_res, rsp_if.event_res)
                   + field_check("value_a", want.value_a, rsp_if.value_a)
                   + field_check("value_b", want.value_b, rsp_if.value_b)
                   + field_check("byte_offset", want.byte_offset, rsp_if.byte_offset)
                   + field_check("message_length", want.message_length,
                                 rsp_if.message_length)
                   + field_check("error_code", want.error_code, rsp_if.error_code)
                   + field_check("target_id", want.target_id, rsp_if.target_id)
                   + field_check("last", want.last, rsp_if.last);
               if (bad != 0)
                  fail_count++;
               results_checked++;
            end
            rsp_hold = draw_wait(rsp_idle_on);
         end
         // stall count also runs down while nothing is offered
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout: %0d results still awaited, %0d frames not taken",
                awaited_events.size(), frames_posted - frames_accepted);
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid      = 1'b0;
      req_if.frame_id   = '0;
      req_if.byte_zero  = '0;
      req_if.byte_one   = '0;
      req_if.byte_two   = '0;
      req_if.byte_three = '0;
      req_if.byte_four  = '0;
      req_if.byte_five  = '0;
      req_if.byte_six   = '0;
      req_if.byte_seven = '0;
      rsp_if.ready      = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, block size 2 so that a mid-message flow control shows up
      apply_setting(ID_W'($urandom), ID_W'($urandom), 8'd2, BYTE_W'($urandom), 1'b1, 1'b1);
      post(mk_frame(foreign_id(), {FT_SINGLE, 4'd3}));        // not our identifier
      post(mk_frame(cfg_channel, {FT_SINGLE, 4'd0}));         // empty single frame
      post(mk_frame(cfg_channel, {FT_SINGLE, SF_MAX_LEN}));   // longest single frame
      post(mk_frame(cfg_channel, {FT_SINGLE, 4'd8}));         // single length too big
      post(mk_frame(cfg_channel, {FT_SINGLE, 4'hF}));
      post(mk_frame(cfg_channel, {FT_CONSEC, SEQ_START}));    // consecutive while idle
      post(mk_frame(cfg_channel, {FT_FLOW, 4'd0}));           // peer flow control
      post(mk_frame(cfg_channel, 8'h40));                     // lowest unknown type
      post(mk_frame(cfg_channel, 8'hFF));                     // highest unknown type
      send_message(12'd0, 1000, 1'b0);                        // zero length leaves idle
      post(mk_frame(cfg_channel, {FT_CONSEC, SEQ_START}));    // so this one is dropped
      send_message(12'd5, 1000, 1'b0);                        // closed by an empty CF
      send_message(12'd30, 1000, 1'b0);                       // flow control after 2 CFs
      post(mk_frame(cfg_channel, {FT_CONSEC, 4'd5}));         // stray CF after completion
      send_message(12'd20, 1000, 1'b1);                       // bad sequence abandons
      send_message(12'hFFF, 2, 1'b0);                         // longest length, cut off
      send_message(12'd12, 1000, 1'b0);                       // restart on a new FF
      random_traffic(PHASE_FRAMES / 2);
      wait_idle();

      // Extremes of the registers, then random ones; idling varies per setting
      apply_setting('0, '1, 8'd0, 8'hFF, 1'b1, 1'b1);
      random_traffic(PHASE_FRAMES);
      wait_idle();

      apply_setting('1, '0, 8'hFF, 8'h00, 1'b0, 1'b0);
      random_traffic(PHASE_FRAMES);
      wait_idle();

      apply_setting(ID_W'($urandom), ID_W'($urandom), 8'd1, BYTE_W'($urandom), 1'b1, 1'b0);
      random_traffic(PHASE_FRAMES);
      wait_idle();

      apply_setting(ID_W'($urandom), ID_W'($urandom), BYTE_W'($urandom_range(2, 8)),
                    BYTE_W'($urandom), 1'b0, 1'b1);
      random_traffic(PHASE_FRAMES);
      wait_idle();

      apply_setting(ID_W'($urandom), ID_W'($urandom), 8'd3, BYTE_W'($urandom), 1'b1, 1'b1);
      random_traffic(PHASE_FRAMES);
      wait_idle();

      $display("Checked %0d results from %0d CAN frames under %0d register settings,",
               results_checked, frames_accepted, settings_count);
      $display("with random idle and stall cycles on both channels.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: isotp_receive_reassembler_top.f
+incdir+rtl/core
rtl/core/isotp_rr_pkg.sv
rtl/core/isotp_rr_req_if.sv
rtl/core/isotp_rr_rsp_if.sv
rtl/core/isotp_rr_decode.sv
rtl/core/isotp_rr_emit.sv
rtl/core/isotp_receive_reassembler_top.sv
tb/sv/tb.sv
